// ----- hw/rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache table.
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic match_found;
    logic victim_found;
    logic free_found;
  } scan_flags_t;

endpackage

// ----- hw/rtl/lfu_cache_table_core.sv -----
// Top level of the LFU cache table with least-recently-touched tie break.
//
// Usage:
//   Request channel (req_valid / req_stall, fields cmd, key, value) takes one
//   get or put transaction at a time. Response channel (rsp_valid / rsp_stall,
//   fields hit, read_value, evicted) returns exactly one transaction per request.
//   Config channel (cfg_valid / cfg_ready, cfg_data) writes cache_capacity; write
//   it only while no request is in flight. cfg_ready is always high.
// Sequence:
//   Each request scans every slot through the single read port of the entry
//   RAM, one slot a cycle, then decides and writes back once, loading the
//   response register from the write state, or from the finish state while it
//   is still held. req_stall stays high until the sequencer is idle again, so
//   the next request is taken only after the previous one is written back.
// Reset:
//   rst is synchronous. After it a clearing pass writes every RAM slot invalid,
//   slot by slot, with req_stall high; config writes are still taken.
// Receiver stall:
//   A finished response waits in the output register; the next request is
//   taken meanwhile, and its own result waits until the register frees up.
module lfu_cache_table_core #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            cmd,
  input  logic signed [lfu_pkg::KEY_W-1:0] key,
  input  logic signed [lfu_pkg::VAL_W-1:0] value,
  // response channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            hit,
  output logic signed [lfu_pkg::VAL_W-1:0] read_value,
  output logic                            evicted,
  // config channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]       cfg_data
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
  localparam int WORD_W = 1 + lfu_pkg::KEY_W + lfu_pkg::VAL_W + COUNT_BITS + lfu_pkg::STAMP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // control state
  logic [2:0]                  state;
  logic [IDX_W-1:0]            slot;
  logic [lfu_pkg::CAP_W-1:0]   cache_capacity;
  logic [OCC_W-1:0]            occupancy;
  logic [lfu_pkg::STAMP_W-1:0] access_clock;
  logic                        step;
  logic                        plan_wr;
  logic                        plan_occ_inc;

  // captured request and write-back plan
  logic                        cmd_r;
  logic [lfu_pkg::KEY_W-1:0]   key_r;
  logic [lfu_pkg::VAL_W-1:0]   value_r;
  logic [IDX_W-1:0]            step_idx;
  logic [IDX_W-1:0]            plan_idx;
  logic [WORD_W-1:0]           plan_word;
  logic                        res_hit;
  logic [lfu_pkg::VAL_W-1:0]   res_value;
  logic                        res_evicted;

  // RAM ports
  logic                        ram_wr_en;
  logic [IDX_W-1:0]            ram_wr_addr;
  logic [WORD_W-1:0]           ram_wr_data;
  logic [WORD_W-1:0]           ram_rd_data;

  // scan results
  lfu_pkg::scan_flags_t        flags;
  logic [IDX_W-1:0]            match_idx;
  logic [IDX_W-1:0]            victim_idx;
  logic [IDX_W-1:0]            free_idx;
  logic [lfu_pkg::VAL_W-1:0]   match_value;
  logic [COUNT_BITS-1:0]       match_count;

  // decision logic
  logic                        req_take;
  logic                        out_free;
  logic                        out_load;
  logic [CMP_W-1:0]            cap_ext;
  logic [CMP_W-1:0]            cap_eff;
  logic                        cap_zero;
  logic                        full;
  logic                        use_free;
  logic [COUNT_BITS-1:0]       bumped;
  logic                        inval_en;
  logic                        dec_wr;
  logic [IDX_W-1:0]            dec_idx;
  logic [WORD_W-1:0]           dec_word;
  logic                        dec_occ_inc;
  logic                        dec_hit;
  logic [lfu_pkg::VAL_W-1:0]   dec_value;
  logic                        dec_ev;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign out_load  = ((state == ST_WRITE) || (state == ST_FINISH)) && out_free;

  lfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  lfu_scan_unit #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (req_take),
    .step        (step),
    .step_idx    (step_idx),
    .entry       (ram_rd_data),
    .key         (key_r),
    .now         (access_clock),
    .flags       (flags),
    .match_idx   (match_idx),
    .victim_idx  (victim_idx),
    .free_idx    (free_idx),
    .match_value (match_value),
    .match_count (match_count)
  );

  // Effective capacity is clamped to the slot count.
  assign cap_ext  = CMP_W'(cache_capacity);
  assign cap_eff  = (cap_ext > ENTRIES_C) ? ENTRIES_C : cap_ext;
  assign cap_zero = (cap_eff == '0);
  assign full     = (CMP_W'(occupancy) >= cap_eff);
  assign use_free = flags.free_found && (free_idx < victim_idx);
  assign bumped   = (match_count == {COUNT_BITS{1'b1}}) ? match_count
                                                        : match_count + COUNT_BITS'(1);

  // Work out the write-back once the scan is complete.
  always_comb begin
    inval_en    = 1'b0;
    dec_wr      = 1'b0;
    dec_idx     = match_idx;
    dec_word    = '0;
    dec_occ_inc = 1'b0;
    dec_hit     = flags.match_found;
    dec_value   = '0;
    dec_ev      = 1'b0;
    if (cmd_r == lfu_pkg::CMD_GET) begin
      if (flags.match_found) begin
        dec_value = match_value;
        dec_wr    = 1'b1;
        dec_word  = {1'b1, key_r, match_value, bumped, access_clock};
      end else begin
        dec_value = '1;
      end
    end else if (!cap_zero) begin
      if (flags.match_found) begin
        dec_wr   = 1'b1;
        dec_word = {1'b1, key_r, value_r, bumped, access_clock};
      end else begin
        dec_wr   = 1'b1;
        dec_word = {1'b1, key_r, value_r, COUNT_BITS'(1), access_clock};
        if (full) begin
          // Evict; the new key lands in the lowest free slot, which may be the victim's.
          dec_ev = flags.victim_found;
          if (use_free) begin
            inval_en = flags.victim_found;
            dec_idx  = free_idx;
          end else begin
            dec_idx = victim_idx;
          end
        end else begin
          dec_idx     = free_idx;
          dec_occ_inc = 1'b1;
        end
      end
    end
  end

  // Single write port: clearing pass, victim invalidation, main write-back.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot;
    ram_wr_data = '0;
    case (state)
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      ST_DECIDE: begin
        ram_wr_en   = inval_en;
        ram_wr_addr = victim_idx;
      end
      ST_WRITE: begin
        ram_wr_en   = plan_wr;
        ram_wr_addr = plan_idx;
        ram_wr_data = plan_word;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      slot           <= '0;
      cache_capacity <= lfu_pkg::CAP_RESET;
      occupancy      <= '0;
      access_clock   <= '0;
      step           <= 1'b0;
      plan_wr        <= 1'b0;
      plan_occ_inc   <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cache_capacity <= cfg_data;
      end
      step <= (state == ST_SCAN);
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (slot == LAST_IDX) begin
            slot  <= '0;
            state <= ST_IDLE;
          end else begin
            slot <= slot + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (req_take) begin
            slot  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (slot == LAST_IDX) begin
            slot  <= '0;
            state <= ST_DRAIN;
          end else begin
            slot <= slot + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          plan_wr      <= dec_wr;
          plan_occ_inc <= dec_occ_inc;
          state        <= ST_WRITE;
        end
        ST_WRITE: begin
          access_clock <= access_clock + lfu_pkg::STAMP_W'(1);
          if (plan_occ_inc) begin
            occupancy <= occupancy + OCC_W'(1);
          end
          state <= out_free ? ST_IDLE : ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    step_idx <= slot;
    if (req_take) begin
      cmd_r   <= cmd;
      key_r   <= key;
      value_r <= value;
    end
    if (state == ST_DECIDE) begin
      plan_idx    <= dec_idx;
      plan_word   <= dec_word;
      res_hit     <= dec_hit;
      res_value   <= dec_value;
      res_evicted <= dec_ev;
    end
    if (out_load) begin
      hit        <= res_hit;
      read_value <= res_value;
      evicted    <= res_evicted;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(occupancy) <= ENTRIES_C)
    else $error("occupancy exceeds slot count");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && evicted) |-> (!hit && (read_value == 0)))
    else $error("eviction reported on a hit or with nonzero read value");

  a_victim_exists: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DECIDE) && (cmd_r == lfu_pkg::CMD_PUT) && !flags.match_found &&
     !cap_zero && full) |-> flags.victim_found)
    else $error("full store without a victim");

  a_free_exists: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DECIDE) && (cmd_r == lfu_pkg::CMD_PUT) && !flags.match_found &&
     !cap_zero && !full) |-> flags.free_found)
    else $error("store not full but no free slot found");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (access_clock == $past(access_clock) + lfu_pkg::STAMP_W'(1)))
    else $error("access clock did not advance by one per request");
`endif

endmodule

// ----- hw/rtl/lfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/lfu_scan_unit.sv -----
// Shared compare unit: key match, victim selection and free slot search over a scan.
module lfu_scan_unit #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int WORD_W = 1 + lfu_pkg::KEY_W + lfu_pkg::VAL_W + COUNT_BITS + lfu_pkg::STAMP_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        step,
  input  logic [IDX_W-1:0]            step_idx,
  input  logic [WORD_W-1:0]           entry,
  input  logic [lfu_pkg::KEY_W-1:0]   key,
  input  logic [lfu_pkg::STAMP_W-1:0] now,
  output lfu_pkg::scan_flags_t        flags,
  output logic [IDX_W-1:0]            match_idx,
  output logic [IDX_W-1:0]            victim_idx,
  output logic [IDX_W-1:0]            free_idx,
  output logic [lfu_pkg::VAL_W-1:0]   match_value,
  output logic [COUNT_BITS-1:0]       match_count
);

  localparam int STAMP_LO = 0;
  localparam int COUNT_LO = lfu_pkg::STAMP_W;
  localparam int VALUE_LO = COUNT_LO + COUNT_BITS;
  localparam int KEY_LO   = VALUE_LO + lfu_pkg::VAL_W;
  localparam int VALID_B  = KEY_LO + lfu_pkg::KEY_W;

  logic                        e_valid;
  logic [lfu_pkg::KEY_W-1:0]   e_key;
  logic [lfu_pkg::VAL_W-1:0]   e_value;
  logic [COUNT_BITS-1:0]       e_count;
  logic [lfu_pkg::STAMP_W-1:0] e_stamp;
  logic [lfu_pkg::STAMP_W-1:0] e_age;
  logic                        better;

  logic [COUNT_BITS-1:0]       victim_count;
  logic [lfu_pkg::STAMP_W-1:0] victim_age;

  assign e_valid = entry[VALID_B];
  assign e_key   = entry[KEY_LO +: lfu_pkg::KEY_W];
  assign e_value = entry[VALUE_LO +: lfu_pkg::VAL_W];
  assign e_count = entry[COUNT_LO +: COUNT_BITS];
  assign e_stamp = entry[STAMP_LO +: lfu_pkg::STAMP_W];
  assign e_age   = now - e_stamp;

  // Strict compares keep the lowest slot on a full tie.
  assign better = !flags.victim_found || (e_count < victim_count) ||
                  ((e_count == victim_count) && (e_age > victim_age));

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (start) begin
      flags <= '0;
    end else if (step) begin
      if (e_valid && (e_key == key) && !flags.match_found) begin
        flags.match_found <= 1'b1;
      end
      if (e_valid && better) begin
        flags.victim_found <= 1'b1;
      end
      if (!e_valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !start) begin
      if (e_valid && (e_key == key) && !flags.match_found) begin
        match_idx   <= step_idx;
        match_value <= e_value;
        match_count <= e_count;
      end
      if (e_valid && better) begin
        victim_idx   <= step_idx;
        victim_count <= e_count;
        victim_age   <= e_age;
      end
      if (!e_valid && !flags.free_found) begin
        free_idx <= step_idx;
      end
    end
  end

endmodule

// ----- test/lfu_cache_table_core_test.sv -----
// Self-checking testbench for the LFU cache table core with its own table predictor.
`timescale 1ns / 1ps

module lfu_cache_table_core_test;

  localparam int SLOTS        = 16;
  localparam int USE_BITS     = 16;
  localparam logic [USE_BITS-1:0] USE_MAX = '1;
  localparam logic [lfu_pkg::VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [lfu_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [lfu_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam int POOL_SIZE    = 32;
  localparam int PHASE_ITEMS  = 144;
  localparam int LONG_HOLD    = 400;
  // Slowest legal run: ~1750 items, each a full scan plus a sender gap and a
  // receiver stall run, plus the long hold; take that several times over.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 3) + 10;

  typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
  } cache_reply_t;

  typedef struct packed {
    logic                      is_cfg;
    logic [lfu_pkg::CAP_W-1:0] cap;
    logic                      op;
    logic [lfu_pkg::KEY_W-1:0] k;
    logic [lfu_pkg::VAL_W-1:0] v;
    logic                      fixed;
    cache_reply_t              want;
  } dir_row_t;

  logic                             clk;
  logic                             rst;
  logic                             req_valid;
  logic                             req_stall;
  logic                             cmd;
  logic signed [lfu_pkg::KEY_W-1:0] key;
  logic signed [lfu_pkg::VAL_W-1:0] value;
  logic                             rsp_valid;
  logic                             rsp_stall;
  logic                             hit;
  logic signed [lfu_pkg::VAL_W-1:0] read_value;
  logic                             evicted;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lfu_pkg::CAP_W-1:0]        cfg_data;

  lfu_cache_table_core #(
    .ENTRIES   (SLOTS),
    .COUNT_BITS(USE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .key       (key),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .hit       (hit),
    .read_value(read_value),
    .evicted   (evicted),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted table contents, mirrored from the block's behavior.
  logic                        cached_valid [SLOTS];
  logic [lfu_pkg::KEY_W-1:0]   cached_key   [SLOTS];
  logic [lfu_pkg::VAL_W-1:0]   cached_value [SLOTS];
  logic [USE_BITS-1:0]         cached_uses  [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] cached_stamp [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] req_clock;
  int                          fill_level;
  logic [lfu_pkg::CAP_W-1:0]   capacity_reg;

  cache_reply_t                pending_replies [$];
  cache_reply_t                oldest_reply;
  dir_row_t                    dir_rows [$];
  logic [lfu_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];
  int                          fail_count;
  int                          cycle_count;
  bit                          long_hold_req;

  // Bump the use count (saturating) and stamp the slot with the current request.
  function automatic void touch_slot(input int s);
    if (cached_uses[s] != USE_MAX) cached_uses[s] = cached_uses[s] + 1'b1;
    cached_stamp[s] = req_clock;
  endfunction

  // Apply one request to the predicted table and return the reply it yields.
  function automatic cache_reply_t lfu_predict(input logic op,
                                               input logic [lfu_pkg::KEY_W-1:0] k,
                                               input logic [lfu_pkg::VAL_W-1:0] v);
    cache_reply_t                r;
    int                          slot;
    int                          dst;
    int                          eff_cap;
    logic [lfu_pkg::STAMP_W-1:0] age;
    logic [lfu_pkg::STAMP_W-1:0] best_age;
    logic [USE_BITS-1:0]         best_uses;
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && cached_valid[i] && cached_key[i] == k) slot = i;
    eff_cap = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
    r.hit = (slot >= 0);
    r.read_value = '0;
    r.evicted = 1'b0;
    if (op == lfu_pkg::CMD_GET) begin
      if (slot >= 0) begin
        r.read_value = cached_value[slot];
        touch_slot(slot);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (eff_cap != 0) begin
      if (slot >= 0) begin
        cached_value[slot] = v;
        touch_slot(slot);
      end else begin
        if (fill_level >= eff_cap) begin
          // Lowest use count loses; ties go to the oldest stamp, then the lowest slot.
          dst = -1;
          best_age = '0;
          best_uses = '0;
          for (int i = 0; i < SLOTS; i++) begin
            if (cached_valid[i]) begin
              age = req_clock - cached_stamp[i];
              if (dst < 0 || cached_uses[i] < best_uses ||
                  (cached_uses[i] == best_uses && age > best_age)) begin
                dst = i;
                best_uses = cached_uses[i];
                best_age = age;
              end
            end
          end
          if (dst >= 0) begin
            cached_valid[dst] = 1'b0;
            fill_level--;
            r.evicted = 1'b1;
          end
        end
        dst = -1;
        for (int i = 0; i < SLOTS; i++)
          if (dst < 0 && !cached_valid[i]) dst = i;
        if (dst >= 0) begin
          cached_valid[dst] = 1'b1;
          cached_key[dst] = k;
          cached_value[dst] = v;
          cached_uses[dst] = USE_BITS'(1);
          cached_stamp[dst] = req_clock;
          fill_level++;
        end
      end
    end
    req_clock = req_clock + 1'b1;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [lfu_pkg::CAP_W-1:0] c);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cap = c;
    return r;
  endfunction

  function automatic dir_row_t req_row(input logic op, input logic [lfu_pkg::KEY_W-1:0] k,
                                       input logic [lfu_pkg::VAL_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.op = op;
    r.k = k;
    r.v = v;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(input logic op, input logic [lfu_pkg::KEY_W-1:0] k,
                                         input logic [lfu_pkg::VAL_W-1:0] v, input logic h,
                                         input logic [lfu_pkg::VAL_W-1:0] rd,
                                         input logic ev);
    dir_row_t r;
    r = req_row(op, k, v);
    r.fixed = 1'b1;
    r.want.hit = h;
    r.want.read_value = rd;
    r.want.evicted = ev;
    return r;
  endfunction

  // Offer one request and hold it until accepted. Call and return at a falling edge.
  task automatic offer(input logic op, input logic [lfu_pkg::KEY_W-1:0] k,
                       input logic [lfu_pkg::VAL_W-1:0] v,
                       input logic fixed, input cache_reply_t want);
    cache_reply_t predicted;
    req_valid <= 1'b1;
    cmd <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (req_stall !== 1'b0);
    // The transaction is taken at this edge: advance the predictor now.
    predicted = lfu_predict(op, k, v);
    pending_replies.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and idle the request side for the span given by n; n of zero does nothing.
  task automatic idle_for(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drain every outstanding reply, then write the capacity register.
  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    capacity_reg = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small pool sized to the capacity, so hits and evictions are
  // common; the rest are extremes and fully random keys.
  function automatic logic [lfu_pkg::KEY_W-1:0] pick_key(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, span - 1)];
    if (r < 90) return key_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-length guard: end the run as failed if it never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lfu_cache_table_core_test failed");
    $finish;
  end

  // Receiver: alternate runs of no stall, light stall and heavy stall; on request,
  // hold off for a long stretch so the block backs up into its request side.
  initial begin
    int run_len;
    int mode;
    rsp_stall = 1'b0;
    long_hold_req = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_stall <= 1'b1;
        for (int n = 0; n < LONG_HOLD; n++) @(negedge clk);
      end else begin
        run_len = $urandom_range(1, 40);
        mode = $urandom_range(0, 2);
        for (int n = 0; n < run_len; n++) begin
          if (mode == 0) rsp_stall <= 1'b0;
          else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
          else rsp_stall <= ($urandom_range(0, 1) == 0);
          @(negedge clk);
        end
      end
    end
  end

  // Reply checker: compare each taken transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: hit=%0d read_value=%h evicted=%0d",
               hit, read_value, evicted);
        fail_count++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (hit !== oldest_reply.hit) begin
          $error("hit: expected %0d, actual %0d", oldest_reply.hit, hit);
          fail_count++;
        end
        if (read_value !== oldest_reply.read_value) begin
          $error("read_value: expected %h, actual %h", oldest_reply.read_value, read_value);
          fail_count++;
        end
        if (evicted !== oldest_reply.evicted) begin
          $error("evicted: expected %0d, actual %0d", oldest_reply.evicted, evicted);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases at several capacities.
  initial begin
    int          phase_caps [$];
    int          span;
    int          eff_cap;
    int          burst_left;
    logic        op;
    dir_row_t    row;
    fail_count = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    cmd = lfu_pkg::CMD_GET;
    key = '0;
    value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;

    // Mirror the reset state of the table.
    for (int i = 0; i < SLOTS; i++) begin
      cached_valid[i] = 1'b0;
      cached_key[i] = '0;
      cached_value[i] = '0;
      cached_uses[i] = '0;
      cached_stamp[i] = '0;
    end
    req_clock = '0;
    fill_level = 0;
    capacity_reg = lfu_pkg::CAP_RESET;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = KEY_MIN;
    key_pool[3] = KEY_MAX;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed table. Typed replies only where they are obvious.
    // Misses on an empty table after reset.
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, '0, '0, 1'b0, MISS_VALUE, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, KEY_MAX, '0, 1'b0, MISS_VALUE, 1'b0));
    // Inserts and reads of the extreme keys and values.
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_PUT, KEY_MIN, KEY_MAX, 1'b0, '0, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_PUT, KEY_MAX, KEY_MIN, 1'b0, '0, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, KEY_MIN, '0, 1'b1, KEY_MAX, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, KEY_MAX, '1, 1'b1, KEY_MIN, 1'b0));
    // Update of a present key.
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_PUT, KEY_MAX, '1, 1'b1, '0, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, KEY_MAX, '0, 1'b1, '1, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, '1, '0, 1'b0, MISS_VALUE, 1'b0));
    // Zero capacity: puts change nothing, but still report hit; gets still find.
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_PUT, 32'd5, 32'd1, 1'b0, '0, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_PUT, KEY_MIN, '0, 1'b1, '0, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, KEY_MIN, '0, 1'b1, KEY_MAX, 1'b0));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_GET, 32'd5, '0, 1'b0, MISS_VALUE, 1'b0));
    // Capacity lowered below occupancy: each new key evicts exactly one.
    dir_rows.push_back(cfg_row(5'd1));
    dir_rows.push_back(fixed_row(lfu_pkg::CMD_PUT, 32'd9, 32'd9, 1'b0, '0, 1'b1));
    dir_rows.push_back(req_row(lfu_pkg::CMD_GET, KEY_MIN, '0));
    dir_rows.push_back(req_row(lfu_pkg::CMD_PUT, 32'd10, 32'd10));
    // Capacity above the slot count behaves as full size.
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(req_row(lfu_pkg::CMD_PUT, '0, '0));
    dir_rows.push_back(req_row(lfu_pkg::CMD_PUT, '1, '1));
    dir_rows.push_back(req_row(lfu_pkg::CMD_GET, '0, '0));
    // Ties on use count: the least recently touched goes first.
    dir_rows.push_back(cfg_row(5'd3));
    dir_rows.push_back(req_row(lfu_pkg::CMD_PUT, 32'd21, 32'd21));
    dir_rows.push_back(req_row(lfu_pkg::CMD_PUT, 32'd22, 32'd22));
    dir_rows.push_back(req_row(lfu_pkg::CMD_GET, 32'd10, '0));
    dir_rows.push_back(cfg_row(5'd16));
    dir_rows.push_back(req_row(lfu_pkg::CMD_PUT, 32'd11, 32'h5A5A_A5A5));
    dir_rows.push_back(req_row(lfu_pkg::CMD_GET, 32'd21, '0));

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        write_capacity(row.cap);
      end else begin
        offer(row.op, row.k, row.v, row.fixed, row.want);
        idle_for($urandom_range(0, 2));
      end
    end

    // Random phases; each starts from a drained block with a new capacity.
    phase_caps = '{16, 4, 1, 0, 31, 8, 2, 17, 3, 5, 0};
    phase_caps.push_back($urandom_range(0, 31));
    burst_left = 0;
    foreach (phase_caps[p]) begin
      write_capacity(lfu_pkg::CAP_W'(phase_caps[p]));
      eff_cap = (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
      span = eff_cap + $urandom_range(1, 8);
      if (span > POOL_SIZE) span = POOL_SIZE;
      // In one phase, let the receiver hold off long enough to back the block up.
      if (p == 1) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 1) == 0) ? lfu_pkg::CMD_GET : lfu_pkg::CMD_PUT;
        offer(op, pick_key(span), $urandom, 1'b0, '0);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0) idle_for(0);
          else if ($urandom_range(0, 7) == 0) idle_for($urandom_range(10, 30));
          else idle_for($urandom_range(1, 8));
        end else begin
          burst_left--;
        end
      end
    end

    // Drain, then allow a few more scans for any stray reply.
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lfu_cache_table_core_test passed");
    end else begin
      $display("lfu_cache_table_core_test failed");
    end
    $finish;
  end

endmodule
